[hw/rtl/thc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_pkg
// Shared types and constants for the temperature / humidity compensation
// pipeline: register indexes, coefficient bundle and polynomial constants.
// ----------------------------------------------------------------------------
package thc_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 24;

  localparam logic [CfgIndexW-1:0] REG_TEMP_COEF_1  = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_TEMP_COEF_2  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_TEMP_COEF_3  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_HUM_COEF_1   = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_HUM_COEF_2   = 3'd4;
  localparam logic [CfgIndexW-1:0] REG_HUM_COEF_3   = 3'd5;
  localparam logic [CfgIndexW-1:0] REG_HUM_COEF_4_5 = 3'd6;
  localparam logic [CfgIndexW-1:0] REG_HUM_COEF_6   = 3'd7;

  localparam logic signed [31:0] FineOffset = 32'sd76800;
  localparam logic signed [31:0] HumRound   = 32'sd16384;
  localparam logic signed [31:0] HumBias    = 32'sd32768;
  localparam logic signed [31:0] HumGainOff = 32'sd2097152;
  localparam logic signed [31:0] GainRound  = 32'sd8192;
  localparam logic signed [31:0] HumMax     = 32'sd419430400;
  localparam logic signed [31:0] TempRound  = 32'sd128;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [7:0]  h1;
    logic [15:0] h2;
    logic [7:0]  h3;
    logic [11:0] h4;
    logic [11:0] h5;
    logic [7:0]  h6;
  } coef_t;

endpackage

[hw/rtl/thc_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_cfg
// Calibration coefficient registers, written through a plain write port.
// ----------------------------------------------------------------------------
module thc_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [thc_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [thc_pkg::CfgDataW-1:0]      cfg_data,
  output thc_pkg::coef_t                    coef
);

  thc_pkg::coef_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        thc_pkg::REG_TEMP_COEF_1:  regs.t1 <= cfg_data[15:0];
        thc_pkg::REG_TEMP_COEF_2:  regs.t2 <= cfg_data[15:0];
        thc_pkg::REG_TEMP_COEF_3:  regs.t3 <= cfg_data[15:0];
        thc_pkg::REG_HUM_COEF_1:   regs.h1 <= cfg_data[7:0];
        thc_pkg::REG_HUM_COEF_2:   regs.h2 <= cfg_data[15:0];
        thc_pkg::REG_HUM_COEF_3:   regs.h3 <= cfg_data[7:0];
        thc_pkg::REG_HUM_COEF_4_5: begin
          regs.h4 <= cfg_data[11:0];
          regs.h5 <= cfg_data[23:12];
        end
        thc_pkg::REG_HUM_COEF_6:   regs.h6 <= cfg_data[7:0];
        default:                   regs <= regs;
      endcase
    end
  end

  assign coef = regs;

endmodule

[hw/rtl/thc_temp_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_temp_pipe
// Three-stage temperature polynomial producing the fine temperature.
// ----------------------------------------------------------------------------
module thc_temp_pipe (
  input  logic                clk,
  input  logic                rst,
  input  thc_pkg::coef_t      coef,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [19:0]         raw_temp,
  input  logic [15:0]         raw_hum,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  fine,
  output logic [15:0]         hum_raw
);

  logic [2:0] vld;
  logic [2:0] en;

  logic signed [31:0] t1s, t2s, t3s;
  logic signed [31:0] a, d;
  logic signed [31:0] m1_next, m2_next, v1_next, m3_next, fine_next;

  logic signed [31:0] m1, m2, v1, m3, fine3;
  logic [15:0] hum1, hum2, hum3;

  always_comb begin
    en[2] = !vld[2] || out_ready;
    en[1] = !vld[1] || en[2];
    en[0] = !vld[0] || en[1];
  end

  assign t1s = $signed({16'd0, coef.t1});
  assign t2s = $signed({{16{coef.t2[15]}}, coef.t2});
  assign t3s = $signed({{16{coef.t3[15]}}, coef.t3});

  always_comb begin
    a         = $signed({15'd0, raw_temp[19:3]}) - $signed({15'd0, coef.t1, 1'b0});
    d         = $signed({16'd0, raw_temp[19:4]}) - t1s;
    m1_next   = a * t2s;
    m2_next   = d * d;
    v1_next   = m1 >>> 11;
    m3_next   = (m2 >>> 12) * t3s;
    fine_next = v1 + (m3 >>> 14);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      if (en[1]) vld[1] <= vld[0];
      if (en[2]) vld[2] <= vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      m1   <= m1_next;
      m2   <= m2_next;
      hum1 <= raw_hum;
    end
    if (en[1]) begin
      v1   <= v1_next;
      m3   <= m3_next;
      hum2 <= hum1;
    end
    if (en[2]) begin
      fine3 <= fine_next;
      hum3  <= hum2;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[2];
  assign fine      = fine3;
  assign hum_raw   = hum3;

endmodule

[hw/rtl/thc_hum_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thc_hum_pipe
// Seven-stage humidity polynomial with clamp; also forms the centi-degree
// temperature and carries the fine temperature to the output register.
// ----------------------------------------------------------------------------
module thc_hum_pipe (
  input  logic                clk,
  input  logic                rst,
  input  thc_pkg::coef_t      coef,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  fine_in,
  input  logic [15:0]         hum_raw,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  temp_centi,
  output logic signed [31:0]  fine_temp,
  output logic [16:0]         hum_q10
);

  localparam int unsigned NumStages = 7;

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] en;

  logic signed [31:0] h1s, h2s, h3s, h4w, h5s, h6s;

  // per-stage payload
  logic signed [31:0] temp_s [NumStages];
  logic signed [31:0] fine_s [NumStages];
  logic signed [31:0] mx6, mx3, mh5;
  logic [15:0]        hum1;
  logic signed [31:0] p2, qm, p3, qh, x4, x5, ss, x6, u;
  logic [16:0]        hum7;

  // next values
  logic signed [31:0] x_next, tsum, temp_next;
  logic signed [31:0] mx6_next, mx3_next, mh5_next;
  logic signed [31:0] p_next, qa, qb, qm_next;
  logic signed [31:0] q0, qh_next;
  logic signed [31:0] q, x2_next;
  logic signed [31:0] s, ss_next;
  logic signed [31:0] u_next;
  logic signed [31:0] xr, xc;
  logic [16:0]        hum_next;

  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || out_ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign h1s = $signed({24'd0, coef.h1});
  assign h2s = $signed({{16{coef.h2[15]}}, coef.h2});
  assign h3s = $signed({24'd0, coef.h3});
  assign h4w = $signed({coef.h4, 20'd0});
  assign h5s = $signed({20'd0, coef.h5});
  assign h6s = $signed({{24{coef.h6[7]}}, coef.h6});

  always_comb begin
    // stage 1: centi temperature, offset fine temperature and its products
    x_next    = fine_in - thc_pkg::FineOffset;
    tsum      = (fine_in <<< 2) + fine_in + thc_pkg::TempRound;
    temp_next = tsum >>> 8;
    mx6_next  = x_next * h6s;
    mx3_next  = x_next * h3s;
    mh5_next  = h5s * x_next;
    // stage 2: offset term and first product of the gain term
    p_next  = ($signed({2'd0, hum1, 14'd0}) - h4w - mh5 + thc_pkg::HumRound) >>> 15;
    qa      = mx6 >>> 10;
    qb      = (mx3 >>> 11) + thc_pkg::HumBias;
    qm_next = qa * qb;
    // stage 3: gain coefficient
    q0      = (qm >>> 10) + thc_pkg::HumGainOff;
    qh_next = q0 * h2s;
    // stage 4: combine offset and gain
    q       = (qh + thc_pkg::GainRound) >>> 14;
    x2_next = p3 * q;
    // stage 5: square of the scaled value
    s       = x4 >>> 15;
    ss_next = s * s;
    // stage 6: quadratic correction
    u_next  = (ss >>> 7) * h1s;
    // stage 7: subtract and clamp to 0..100 percent
    xr = x6 - (u >>> 4);
    if (xr < 0) begin
      xc = '0;
    end else if (xr > thc_pkg::HumMax) begin
      xc = thc_pkg::HumMax;
    end else begin
      xc = xr;
    end
    hum_next = xc[28:12];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      temp_s[0] <= temp_next;
      fine_s[0] <= fine_in;
      mx6       <= mx6_next;
      mx3       <= mx3_next;
      mh5       <= mh5_next;
      hum1      <= hum_raw;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        temp_s[k] <= temp_s[k-1];
        fine_s[k] <= fine_s[k-1];
      end
    end
    if (en[1]) begin
      p2 <= p_next;
      qm <= qm_next;
    end
    if (en[2]) begin
      p3 <= p2;
      qh <= qh_next;
    end
    if (en[3]) x4 <= x2_next;
    if (en[4]) begin
      x5 <= x4;
      ss <= ss_next;
    end
    if (en[5]) begin
      x6 <= x5;
      u  <= u_next;
    end
    if (en[6]) hum7 <= hum_next;
  end

  assign in_ready   = en[0];
  assign out_valid  = vld[NumStages-1];
  assign temp_centi = temp_s[NumStages-1];
  assign fine_temp  = fine_s[NumStages-1];
  assign hum_q10    = hum7;

endmodule

[hw/rtl/temp_humidity_compensation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temp_humidity_compensation
// Integer calibration of raw temperature and humidity readings.
//
// Input channel: in_valid / in_ready carry one word of raw_temp (20 bit) and
// raw_hum (16 bit). Output channel: out_valid / out_ready carry temp_centi,
// fine_temp and hum_q10 (humidity percent * 1024, clamped to 0..102400).
// Coefficients are loaded through cfg_we / cfg_index / cfg_data while no word
// is in flight; each write lands at the clock edge with cfg_we high.
//
// Ten register stages: a word accepted at the input passes all of them, in
// order, before out_valid rises. Three stages
// form the fine temperature and seven the humidity polynomial, one multiply
// per dependent step; throughput is one word per cycle with out_ready high.
// Each stage holds its own valid bit and loads when it is empty or the next
// stage moves, so a stalled receiver only backs up the full stages; bubbles
// are squeezed out and no word is dropped or repeated. in_ready falls only
// when all ten stages hold a word and out_ready is low.
// Synchronous reset empties the pipeline and clears all coefficients to zero.
// ----------------------------------------------------------------------------
module temp_humidity_compensation (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [thc_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [thc_pkg::CfgDataW-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [19:0]                       raw_temp,
  input  logic [15:0]                       raw_hum,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                temp_centi,
  output logic signed [31:0]                fine_temp,
  output logic [16:0]                       hum_q10
);

  thc_pkg::coef_t      coef;
  logic                mid_valid;
  logic                mid_ready;
  logic signed [31:0]  mid_fine;
  logic [15:0]         mid_hum;

  thc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  thc_temp_pipe u_temp (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .raw_temp  (raw_temp),
    .raw_hum   (raw_hum),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .fine      (mid_fine),
    .hum_raw   (mid_hum)
  );

  thc_hum_pipe u_hum (
    .clk        (clk),
    .rst        (rst),
    .coef       (coef),
    .in_valid   (mid_valid),
    .in_ready   (mid_ready),
    .fine_in    (mid_fine),
    .hum_raw    (mid_hum),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .temp_centi (temp_centi),
    .fine_temp  (fine_temp),
    .hum_q10    (hum_q10)
  );

  // reset empties every stage
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // input backpressure only when the whole pipe is full and blocked
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && mid_valid && !mid_ready))
    else $error("input stalled while pipeline has room");

  // clamp keeps humidity within 0..100 percent
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hum_q10 <= 17'd102400))
    else $error("humidity above full scale");

  // a word held between the two halves keeps its fine temperature and raw humidity
  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (mid_valid && !mid_ready) |=> (mid_valid && $stable(mid_fine) && $stable(mid_hum)))
    else $error("word between halves lost or changed while stalled");

endmodule
